>>> design/gdas_pkg.sv
// Types, constants and calendar helpers for the Gregorian date add/sub block.
// Used by the controller, the datapath and the top level. No dependencies.
package gdas_pkg;

  localparam logic [13:0] YEAR_MIN    = 14'd1;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [6:0]  YMOD_LAST   = 7'd99;
  localparam logic [13:0] CENTURY     = 14'd100;

  // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for y <= 9999
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic [4:0] LEN_FEB_LEAP = 5'd29;
  localparam logic [4:0] LEN_FEB      = 5'd28;
  localparam logic [4:0] LEN_SHORT    = 5'd30;
  localparam logic [4:0] LEN_LONG     = 5'd31;

  typedef struct packed {
    logic        mode;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] day_count;
  } req_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic        year_overflow;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic prep;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } status_t;

  function automatic logic is_leap(logic [1:0] y_mod4, logic [6:0] y_mod100,
                                   logic [1:0] cen_mod4);
    logic div4;
    logic div100;
    div4   = (y_mod4 == 2'd0);
    div100 = (y_mod100 == 7'd0);
    return (div4 && !div100) || (div100 && (cen_mod4 == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] month, logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                       len = leap ? LEN_FEB_LEAP : LEN_FEB;
      4'd4, 4'd6, 4'd9, 4'd11:    len = LEN_SHORT;
      default:                    len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

>>> design/gdas_ctrl.sv
// Sequencer for the date walk: load, year split, day clamp, month steps.
// Depends on gdas_pkg for the command and status structs.
module gdas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  output logic              rsp_valid_o,
  input  logic              rsp_stall_i,
  input  gdas_pkg::status_t status_i,
  output gdas_pkg::cmd_t    cmd_o
);
  import gdas_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_REM  = 5'b00100,
    ST_PREP = 5'b01000,
    ST_WALK = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !rsp_stall_i;
  assign req_stall_o = (state_q != ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        if (!status_i.walk_done) begin
          cmd_o.step = 1'b1;
        end else if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!rsp_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/gdas_dpath.sv
// Datapath: clamped date registers, year mod-100 split, month stepper, result register.
// Depends on gdas_pkg for payload types, constants and calendar helpers.
module gdas_dpath (
  input  logic              clk_i,
  input  gdas_pkg::req_t    req_i,
  input  gdas_pkg::cmd_t    cmd_i,
  output gdas_pkg::status_t status_o,
  output gdas_pkg::rsp_t    rsp_o
);
  import gdas_pkg::*;

  logic               mode_q;
  logic [4:0]         sday_q;
  logic [15:0]        count_q;
  logic [3:0]         month_q, month_d;
  logic [13:0]        year_q, year_d;
  logic [6:0]         quot_q;
  logic [6:0]         ymod_q, ymod_d;
  logic [1:0]         cen_q, cen_d;
  logic signed [17:0] day_q, day_d;
  logic               ovf_q, ovf_d;
  rsp_t               rsp_q;

  logic [3:0]  month_in;
  logic [13:0] year_in;
  logic [26:0] prod;
  logic [13:0] rem_full;
  logic [4:0]  len_cur;
  logic [4:0]  len_nxt;
  logic [4:0]  day_clamp;
  logic        leap_cur;
  logic        leap_nxt;
  logic        done;

  // input saturation
  always_comb begin
    month_in = req_i.start_month;
    if (month_in < MONTH_FIRST) month_in = MONTH_FIRST;
    if (month_in > MONTH_LAST)  month_in = MONTH_LAST;
    year_in = req_i.start_year;
    if (year_in < YEAR_MIN) year_in = YEAR_MIN;
    if (year_in > YEAR_MAX) year_in = YEAR_MAX;
  end

  assign prod     = 27'(year_q) * 27'(DIV100_MUL);
  assign rem_full = year_q - 14'(quot_q) * CENTURY;

  assign leap_cur = is_leap(year_q[1:0], ymod_q, cen_q);
  assign len_cur  = month_len(month_q, leap_cur);

  always_comb begin
    day_clamp = sday_q;
    if (day_clamp == 5'd0)   day_clamp = 5'd1;
    if (day_clamp > len_cur) day_clamp = len_cur;
  end

  assign done = ovf_q || (mode_q ? (day_q >= 18'sd1)
                                 : (day_q <= $signed({13'd0, len_cur})));
  assign status_o.walk_done = done;

  // one month per step
  always_comb begin
    month_d = month_q;
    year_d  = year_q;
    ymod_d  = ymod_q;
    cen_d   = cen_q;
    ovf_d   = ovf_q;
    if (!mode_q) begin
      if (month_q == MONTH_LAST) begin
        month_d = MONTH_FIRST;
        if (year_q >= YEAR_MAX) begin
          ovf_d = 1'b1;
        end else begin
          year_d = year_q + 14'd1;
          if (ymod_q == YMOD_LAST) begin
            ymod_d = 7'd0;
            cen_d  = cen_q + 2'd1;
          end else begin
            ymod_d = ymod_q + 7'd1;
          end
        end
      end else begin
        month_d = month_q + 4'd1;
      end
    end else begin
      if (month_q == MONTH_FIRST) begin
        month_d = MONTH_LAST;
        if (year_q <= YEAR_MIN) begin
          ovf_d = 1'b1;
        end else begin
          year_d = year_q - 14'd1;
          if (ymod_q == 7'd0) begin
            ymod_d = YMOD_LAST;
            cen_d  = cen_q - 2'd1;
          end else begin
            ymod_d = ymod_q - 7'd1;
          end
        end
      end else begin
        month_d = month_q - 4'd1;
      end
    end
    leap_nxt = is_leap(year_d[1:0], ymod_d, cen_d);
    len_nxt  = month_len(month_d, leap_nxt);
    if (!mode_q) begin
      day_d = day_q - $signed({13'd0, len_cur});
    end else if (ovf_d) begin
      day_d = day_q;
    end else begin
      day_d = day_q + $signed({13'd0, len_nxt});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= req_i.mode;
      sday_q  <= req_i.start_day;
      count_q <= req_i.day_count;
      month_q <= month_in;
      year_q  <= year_in;
    end
    if (cmd_i.div) begin
      quot_q <= prod[DIV100_SHIFT +: 7];
    end
    if (cmd_i.rem) begin
      ymod_q <= rem_full[6:0];
      cen_q  <= quot_q[1:0];
    end
    if (cmd_i.prep) begin
      ovf_q <= 1'b0;
      if (!mode_q) begin
        day_q <= $signed({13'd0, day_clamp}) + $signed({2'd0, count_q});
      end else begin
        day_q <= $signed({13'd0, day_clamp}) - $signed({2'd0, count_q});
      end
    end
    if (cmd_i.step) begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      ymod_q  <= ymod_d;
      cen_q   <= cen_d;
      ovf_q   <= ovf_d;
    end
    if (cmd_i.out_load) begin
      rsp_q.year_overflow <= ovf_q;
      if (ovf_q && !mode_q) begin
        rsp_q.result_day   <= LEN_LONG;
        rsp_q.result_month <= MONTH_LAST;
        rsp_q.result_year  <= YEAR_MAX;
      end else if (ovf_q) begin
        rsp_q.result_day   <= 5'd1;
        rsp_q.result_month <= MONTH_FIRST;
        rsp_q.result_year  <= YEAR_MIN;
      end else begin
        rsp_q.result_day   <= day_q[4:0];
        rsp_q.result_month <= month_q;
        rsp_q.result_year  <= year_q;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

>>> design/gregorian_date_add_sub_days_top.sv
// Gregorian date plus/minus day count: top level joining controller and datapath.
// Depends on gdas_pkg, gdas_ctrl and gdas_dpath.
//
// Usage:
//   Request channel (req_valid_i / req_stall_o / req_i) takes a start date, a
//   day count and a mode (0 add, 1 subtract). Response channel (rsp_valid_o /
//   rsp_stall_i / rsp_o) returns the resulting date and an overflow flag.
//   A transfer happens on a clock edge with valid high and stall low.
//   After the accepting edge the controller runs DIV, REM and PREP, then one
//   WALK step per month boundary crossed (up to about 2160 for 65535 days).
//   The month stepper handles one month per cycle; the year is split into
//   mod-100 and century parts in the DIV and REM states before the walk starts.
//   One request is in flight at a time; req_stall_o is high while busy.
//   A finished response sits in the output register, so the next request is
//   taken while the previous response waits; a stalled response holds its
//   value and only blocks the block from finishing the following request.
//   Reset clears the controller: idle, no response pending.
module gregorian_date_add_sub_days_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  gdas_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output gdas_pkg::rsp_t rsp_o
);
  import gdas_pkg::*;

  cmd_t    cmd;
  status_t status;

  gdas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gdas_dpath u_dpath (
    .clk_i    (clk_i),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (rsp_o)
  );

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp_valid_o || !rsp_stall_i))
    else $error("pending response overwritten");

  a_busy_after_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !req_stall_o) |=> req_stall_o)
    else $error("request taken while not busy afterwards");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> rsp_valid_o)
    else $error("loaded response not presented");

  a_step_not_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !status.walk_done)
    else $error("month step after walk finished");

endmodule
